### rtl/block_image_stream_checker_defines.svh
// Assertion macros used by the checker file of the block image stream checker.
`ifndef BLOCK_IMAGE_STREAM_CHECKER_DEFINES_SVH
`define BLOCK_IMAGE_STREAM_CHECKER_DEFINES_SVH

// Same-cycle implication, clocked on clock, off while reset is high.
`define BISC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off while reset is high.
`define BISC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bisc_pkg.sv
// Types and constants of the block image stream checker.
package bisc_pkg;

   localparam int BYTE_W     = 8;
   localparam int DIM_W      = 31;
   localparam int SIZE_W     = 32;
   localparam int COUNT_W    = 64;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int STATUS_W   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_TYPE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TYPE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAY        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RGB         = 3'd4;

   // Verdict codes
   localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_HEADER  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_COLOUR  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NEG_DIM     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NON_DATA    = 4'd6;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 4'd7;
   localparam logic [STATUS_W-1:0] ST_TOO_FEW     = 4'd8;
   localparam logic [STATUS_W-1:0] ST_NEG_SIZE    = 4'd9;

   localparam logic [SIZE_W-1:0] HEADER_SIZE = 32'd9;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      logic                pixel_valid;
      logic [BYTE_W-1:0]   pixel_byte;
      logic                final_res;
      logic [STATUS_W-1:0] status;
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic                is_rgb;
   } rsp_word_type;

   // Image geometry handed to the expected byte count unit
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             rgb;
   } dims_type;

endpackage

### rtl/bisc_if.sv
// Stream channel interfaces of the block image stream checker.
interface bisc_req_if;
   logic                  valid;
   logic                  ready;
   bisc_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bisc_rsp_if;
   logic                  valid;
   logic                  ready;
   bisc_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/bisc_expect.sv
// Expected pixel byte count: width * height, times three for RGB, two register stages.
module bisc_expect (
   input  logic                               clock,
   input  bisc_pkg::dims_type                 dims,
   output logic [bisc_pkg::COUNT_W-1:0]       expected
);

   logic [bisc_pkg::PROD_W-1:0]  prod_ff;
   logic [bisc_pkg::PROD_W-1:0]  prod_in;
   logic                         rgb_ff;
   logic [bisc_pkg::COUNT_W-1:0] expected_ff;
   logic [bisc_pkg::COUNT_W-1:0] expected_in;

   // 31 x 31 unsigned, full 62-bit product
   assign prod_in = bisc_pkg::PROD_W'(dims.width) * bisc_pkg::PROD_W'(dims.height);

   // times three as p + 2p
   assign expected_in = rgb_ff
      ? ({2'b00, prod_ff} + {1'b0, prod_ff, 1'b0})
      : {2'b00, prod_ff};

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      rgb_ff      <= dims.rgb;
      expected_ff <= expected_in;
   end

   assign expected = expected_ff;

endmodule

### rtl/block_image_stream_checker.sv
// Block image stream checker: top level, byte parser and result register.
//
// Takes a block image file one byte per word on req_if and checks it: a
// 16-bit little-endian magic, a header block (type byte, 32-bit LE size
// that must be 9, width, height, colour byte), then data blocks whose
// payload bytes come out on rsp_if as pixel bytes. The word marked
// last_byte always yields a result carrying the verdict (status) and, when
// the file is good, the image geometry; the parser then starts over.
// Every byte that is not a passed pixel byte and not the last one yields
// no result. After an error the rest of the file is swallowed.
// Rate: one byte per clock, sustained; a byte is taken in the cycle it is
// offered while the result register is empty or being drained, and its
// result is registered in the result register. The expected pixel
// byte count comes from a two-stage multiply unit that settles well
// before the first data block size is complete. Configuration (csr_*)
// must be written only while no file is in flight; the block itself does
// not enforce this. There is no clearing pass after reset.
module block_image_stream_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   bisc_req_if.sink                              req_if,
   bisc_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [bisc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bisc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Parser phases
   localparam logic [2:0] PH_MAGIC = 3'd0;
   localparam logic [2:0] PH_HTYPE = 3'd1;
   localparam logic [2:0] PH_HSIZE = 3'd2;
   localparam logic [2:0] PH_HPAY  = 3'd3;
   localparam logic [2:0] PH_DTYPE = 3'd4;
   localparam logic [2:0] PH_DSIZE = 3'd5;
   localparam logic [2:0] PH_DPAY  = 3'd6;
   localparam logic [2:0] PH_ERROR = 3'd7;

   // Configuration registers
   logic [15:0] magic_cfg_ff;
   logic [7:0]  hdr_type_cfg_ff;
   logic [7:0]  data_type_cfg_ff;
   logic [7:0]  gray_cfg_ff;
   logic [7:0]  rgb_cfg_ff;

   // Parser state
   logic [2:0]  phase_ff,      phase_in;
   logic [1:0]  idx_ff,        idx_in;
   logic [7:0]  magic_low_ff,  magic_low_in;
   logic [7:0]  kind_ff,       kind_in;
   logic [31:0] size_ff,       size_in;
   logic [30:0] left_ff,       left_in;
   logic [30:0] width_ff,      width_in;
   logic [31:0] height_ff,     height_in;
   logic        rgb_ff,        rgb_in;
   logic [63:0] received_ff,   received_in;
   logic [3:0]  err_ff,        err_in;
   logic        bad_ff,        bad_in;
   logic        accept_ff,     accept_in;

   // Result register
   logic                   rsp_valid_ff;
   bisc_pkg::rsp_word_type rsp_word_ff;
   bisc_pkg::rsp_word_type rsp_word_in;

   logic        go;
   logic [7:0]  b;
   logic        last;
   logic        pix;
   logic        hdr_done;
   logic        result;
   logic [31:0] size_byte;
   logic [63:0] recv_sum;
   logic        accept_new;
   logic        in_window;
   logic [3:0]  pos;
   logic        bad_data;
   logic [3:0]  status;
   logic [63:0] expected;
   bisc_pkg::dims_type dims;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign go   = req_if.valid && req_if.ready;
   assign b    = req_if.data.byte_in;
   assign last = req_if.data.last_byte;

   assign dims.width  = width_ff;
   assign dims.height = height_ff[30:0];
   assign dims.rgb    = rgb_ff;

   bisc_expect u_expect (
      .clock    (clock),
      .dims     (dims),
      .expected (expected)
   );

   // size field with the current byte dropped into its lane
   assign size_byte  = size_ff | (32'(b) << {idx_ff, 3'b000});
   assign recv_sum   = received_ff + {32'b0, size_byte};
   assign accept_new = recv_sum <= expected;
   assign bad_data   = kind_ff != data_type_cfg_ff;

   // header payload position; only the last nine bytes of the block count
   assign in_window = left_ff <= 31'd9;
   assign pos       = 4'(4'd9 - left_ff[3:0]);

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      magic_low_in = magic_low_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      left_in      = left_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rgb_in       = rgb_ff;
      received_in  = received_ff;
      err_in       = err_ff;
      bad_in       = bad_ff;
      accept_in    = accept_ff;
      pix          = 1'b0;
      hdr_done     = 1'b0;

      unique case (phase_ff)
         PH_MAGIC: begin
            if (idx_ff == 2'd0) begin
               magic_low_in = b;
               idx_in       = 2'd1;
            end else if ({b, magic_low_ff} != magic_cfg_ff) begin
               phase_in = PH_ERROR;
               err_in   = bisc_pkg::ST_BAD_MAGIC;
            end else begin
               phase_in = PH_HTYPE;
            end
         end
         PH_HTYPE, PH_DTYPE: begin
            kind_in  = b;
            idx_in   = 2'd0;
            size_in  = '0;
            phase_in = phase_ff + 3'd1;
         end
         PH_HSIZE, PH_DSIZE: begin
            size_in = size_byte;
            idx_in  = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               if (size_byte[31]) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_NEG_SIZE;
               end else begin
                  left_in = size_byte[30:0];
                  if (phase_ff == PH_HSIZE) begin
                     bad_in    = (kind_ff != hdr_type_cfg_ff) ||
                                 (size_byte != bisc_pkg::HEADER_SIZE);
                     size_in   = '0;
                     height_in = '0;
                     // an empty header can never be the right size
                     if (size_byte == 32'd0) begin
                        phase_in = PH_ERROR;
                        err_in   = bisc_pkg::ST_BAD_HEADER;
                     end else begin
                        phase_in = PH_HPAY;
                     end
                  end else begin
                     bad_in    = bad_data;
                     accept_in = !bad_data && accept_new;
                     if (!bad_data) begin
                        received_in = recv_sum;
                     end
                     if (size_byte != 32'd0) begin
                        phase_in = PH_DPAY;
                     end else if (bad_data) begin
                        phase_in = PH_ERROR;
                        err_in   = bisc_pkg::ST_NON_DATA;
                     end else if (!accept_new) begin
                        phase_in = PH_ERROR;
                        err_in   = bisc_pkg::ST_TOO_MANY;
                     end else begin
                        phase_in = PH_DTYPE;
                     end
                  end
               end
            end
         end
         PH_HPAY: begin
            if (in_window && pos[3:2] == 2'b00) begin
               size_in = size_ff | (32'(b) << {pos[1:0], 3'b000});
            end else if (in_window && pos[3:2] == 2'b01) begin
               height_in = height_ff | (32'(b) << {pos[1:0], 3'b000});
            end
            left_in = left_ff - 31'd1;
            // on the closing byte of a good header, b is the colour byte
            if (left_ff == 31'd1) begin
               if (bad_ff) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_BAD_HEADER;
               end else if (b != gray_cfg_ff && b != rgb_cfg_ff) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_BAD_COLOUR;
               end else if (size_ff[31] || height_ff[31]) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_NEG_DIM;
               end else begin
                  width_in = size_ff[30:0];
                  rgb_in   = b != gray_cfg_ff;
                  phase_in = PH_DTYPE;
                  hdr_done = 1'b1;
               end
            end
         end
         PH_DPAY: begin
            pix     = accept_ff;
            left_in = left_ff - 31'd1;
            if (left_ff == 31'd1) begin
               if (bad_ff) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_NON_DATA;
               end else if (!accept_ff) begin
                  phase_in = PH_ERROR;
                  err_in   = bisc_pkg::ST_TOO_MANY;
               end else begin
                  phase_in = PH_DTYPE;
               end
            end
         end
         PH_ERROR: begin
            // swallow the rest of the file
         end
      endcase
   end

   // Verdict as seen after this byte. Right after the header the expected
   // count is still in the multiplier, but it is nonzero exactly when both
   // dimensions are.
   always_comb begin
      priority if (phase_in == PH_ERROR) begin
         status = err_in;
      end else if (phase_in == PH_MAGIC) begin
         status = bisc_pkg::ST_BAD_MAGIC;
      end else if (phase_in == PH_DTYPE) begin
         if (hdr_done) begin
            status = (width_in != 31'd0 && height_ff[30:0] != 31'd0)
                     ? bisc_pkg::ST_TOO_FEW : bisc_pkg::ST_OK;
         end else begin
            status = (received_ff != expected) ? bisc_pkg::ST_TOO_FEW : bisc_pkg::ST_OK;
         end
      end else begin
         status = bisc_pkg::ST_TRUNCATED;
      end
   end

   assign result = pix || last;

   always_comb begin
      rsp_word_in              = '0;
      rsp_word_in.pixel_valid  = pix;
      rsp_word_in.pixel_byte   = pix ? b : 8'd0;
      rsp_word_in.final_res    = last;
      if (last) begin
         rsp_word_in.status = status;
         if (status == bisc_pkg::ST_OK) begin
            rsp_word_in.image_width  = width_in;
            rsp_word_in.image_height = height_in[30:0];
            rsp_word_in.is_rgb       = rgb_in;
         end
      end
   end

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff     <= 16'd0;
         hdr_type_cfg_ff  <= 8'd0;
         data_type_cfg_ff <= 8'd1;
         gray_cfg_ff      <= 8'd0;
         rgb_cfg_ff       <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            bisc_pkg::CSR_MAGIC:       magic_cfg_ff     <= csr_wdata;
            bisc_pkg::CSR_HEADER_TYPE: hdr_type_cfg_ff  <= csr_wdata[7:0];
            bisc_pkg::CSR_DATA_TYPE:   data_type_cfg_ff <= csr_wdata[7:0];
            bisc_pkg::CSR_GRAY:        gray_cfg_ff      <= csr_wdata[7:0];
            bisc_pkg::CSR_RGB:         rgb_cfg_ff       <= csr_wdata[7:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // Parser state; the last byte of a file sends everything back to start
   always_ff @(posedge clock) begin
      if (reset || (go && last)) begin
         phase_ff     <= PH_MAGIC;
         idx_ff       <= 2'd0;
         magic_low_ff <= 8'd0;
         kind_ff      <= 8'd0;
         size_ff      <= 32'd0;
         left_ff      <= 31'd0;
         width_ff     <= 31'd0;
         height_ff    <= 32'd0;
         rgb_ff       <= 1'b0;
         received_ff  <= 64'd0;
         err_ff       <= bisc_pkg::ST_OK;
         bad_ff       <= 1'b0;
         accept_ff    <= 1'b0;
      end else if (go) begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         magic_low_ff <= magic_low_in;
         kind_ff      <= kind_in;
         size_ff      <= size_in;
         left_ff      <= left_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rgb_ff       <= rgb_in;
         received_ff  <= received_in;
         err_ff       <= err_in;
         bad_ff       <= bad_in;
         accept_ff    <= accept_in;
      end
   end

   // Result register: refilled or emptied whenever the sink side moves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         rsp_valid_ff <= go && result;
      end
   end

   always_ff @(posedge clock) begin
      if (go && result) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_word_ff;

endmodule

### rtl/bisc_checker.sv
// Port-level assertions of the block image stream checker and their bind.
`include "block_image_stream_checker_defines.svh"

module bisc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bisc_pkg::rsp_word_type rsp_data
);

   // A held result blocks new bytes
   `BISC_ASSERT_IMPL(a_stall_blocks_input, rsp_valid && !rsp_ready && req_valid, !req_ready, "byte taken while result held")

   // A stalled result stays put
   `BISC_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Mid-file results are clean pixel bytes
   `BISC_ASSERT_IMPL(a_mid_is_pixel, rsp_valid && !rsp_data.final_res, rsp_data.pixel_valid && rsp_data.status == bisc_pkg::ST_OK, "mid-file result without pixel")

   // A failed verdict carries no geometry
   `BISC_ASSERT_IMPL(a_fail_no_geom, rsp_valid && rsp_data.status != bisc_pkg::ST_OK, rsp_data.final_res && rsp_data.image_width == '0 && rsp_data.image_height == '0 && !rsp_data.is_rgb, "geometry on failed verdict")

   // Verdict is within the defined codes
   `BISC_ASSERT_IMPL(a_status_range, rsp_valid, rsp_data.status <= bisc_pkg::ST_NEG_SIZE, "undefined status code")

endmodule

bind block_image_stream_checker bisc_checker u_bisc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
